### rtl/tdt_pkg.sv
package tdt_pkg;

	// Widths of the configuration port.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_TAP_RADIUS    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TAP_WINDOW    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_WINDOW = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_TAP    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_DOUBLE = 3'd4;

	// Register values after reset.
	localparam logic [7:0]  RADIUS_RESET        = 8'd3;
	localparam logic [15:0] TAP_WINDOW_RESET    = 16'd200;
	localparam logic [15:0] DOUBLE_WINDOW_RESET = 16'(2 * 200);

	// Depths of the queue between front and back and of the result queue.
	localparam int MID_DEPTH_DEFAULT = 2;
	localparam int OUT_DEPTH_DEFAULT = 2;

	// Action codes of an incoming event.
	localparam logic [2:0] ACT_DOWN  = 3'd0;
	localparam logic [2:0] ACT_UP    = 3'd1;
	localparam logic [2:0] ACT_MOVE  = 3'd2;
	localparam logic [2:0] ACT_OTHER = 3'd3;
	localparam logic [2:0] ACT_TICK  = 3'd4;

	// Event class as decoded by the front part.
	typedef enum logic [2:0] {
		CLS_DOWN,
		CLS_UP,
		CLS_MOVE,
		CLS_OTHER,
		CLS_TICK,
		CLS_IGNORE
	} cls_t;

	// Outcome codes of a result.
	typedef enum logic [2:0] {
		OUT_IDLE    = 3'd0,
		OUT_PENDING = 3'd1,
		OUT_TAP     = 3'd2,
		OUT_DOUBLE  = 3'd3,
		OUT_FAIL    = 3'd4
	} outcome_t;

	// One incoming pointer event.
	typedef struct packed {
		logic [2:0]         action;
		logic [3:0]         pointer_id;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [31:0]        stamp_ms;
	} in_item_t;

	// One result.
	typedef struct packed {
		logic [2:0]         outcome;
		logic signed [15:0] gesture_x;
		logic signed [15:0] gesture_y;
	} out_item_t;

	// A classified event as queued between front and back.
	typedef struct packed {
		cls_t               cls;
		logic [3:0]         pointer_id;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [31:0]        stamp_ms;
	} cmd_t;

	// One configuration write.
	typedef struct packed {
		logic                   we;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_wr_t;

endpackage

### rtl/tdt_fifo.sv
module tdt_fifo #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	// Status and read side.
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/tdt_front.sv
module tdt_front import tdt_pkg::*; #(
	parameter int MID_DEPTH = MID_DEPTH_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t event_item,
	output logic     cmd_valid,
	input  logic     cmd_take,
	output cmd_t     cmd
);

	cmd_t cls_item;
	logic mid_empty;

	// Decode the action code into an event class.
	always_comb begin
		cls_item.pointer_id = event_item.pointer_id;
		cls_item.pos_x      = event_item.pos_x;
		cls_item.pos_y      = event_item.pos_y;
		cls_item.stamp_ms   = event_item.stamp_ms;
		unique case (event_item.action)
			ACT_DOWN:  cls_item.cls = CLS_DOWN;
			ACT_UP:    cls_item.cls = CLS_UP;
			ACT_MOVE:  cls_item.cls = CLS_MOVE;
			ACT_OTHER: cls_item.cls = CLS_OTHER;
			ACT_TICK:  cls_item.cls = CLS_TICK;
			default:   cls_item.cls = CLS_IGNORE;
		endcase
	end

	// Short queue that decouples intake from evaluation.
	tdt_fifo #(
		.DEPTH (MID_DEPTH),
		.WIDTH ($bits(cmd_t))
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls_item),
		.full   (full),
		.pop    (cmd_take),
		.rdata  (cmd),
		.empty  (mid_empty)
	);

	assign cmd_valid = !mid_empty;

endmodule

### rtl/tdt_back.sv
module tdt_back import tdt_pkg::*; #(
	parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_wr_t   cfg,
	input  logic      cmd_valid,
	output logic      cmd_take,
	input  cmd_t      cmd,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	// Configuration registers.
	logic [7:0]  radius_q;
	logic [15:0] radius_sq_q;
	logic [15:0] tap_window_q;
	logic [15:0] double_window_q;
	logic        en_tap_q;
	logic        en_double_q;

	// Candidate state.
	logic               active_q;
	logic               single_alive_q;
	logic               single_done_q;
	logic               double_alive_q;
	logic               ups_seen_q;
	logic signed [15:0] start_x_q;
	logic signed [15:0] start_y_q;
	logic [31:0]        start_time_q;
	logic [3:0]         owner_q;

	// Next state.
	logic               n_active;
	logic               n_single;
	logic               n_done;
	logic               n_double;
	logic               n_ups;
	logic signed [15:0] n_start_x;
	logic signed [15:0] n_start_y;
	logic [31:0]        n_start_time;
	logic [3:0]         n_owner;

	logic      do_resolve;
	logic      do_begin;
	logic      began_idle;
	outcome_t  code;
	out_item_t res_item;
	logic      out_full;

	// Elapsed time and window checks.
	logic [31:0] elapsed;
	logic        el_le_tap;
	logic        el_le_double;

	assign elapsed      = cmd.stamp_ms - start_time_q;
	assign el_le_tap    = (elapsed <= 32'(tap_window_q));
	assign el_le_double = (elapsed <= 32'(double_window_q));

	// Distance check: a box test first, then exact squares on eight-bit offsets.
	logic [16:0] dx;
	logic [16:0] dy;
	logic [16:0] adx;
	logic [16:0] ady;
	logic        in_box;
	logic [15:0] sq_x;
	logic [15:0] sq_y;
	logic [16:0] dist_sq;
	logic        near;

	assign dx      = {cmd.pos_x[15], cmd.pos_x} - {start_x_q[15], start_x_q};
	assign dy      = {cmd.pos_y[15], cmd.pos_y} - {start_y_q[15], start_y_q};
	assign adx     = dx[16] ? (~dx + 17'd1) : dx;
	assign ady     = dy[16] ? (~dy + 17'd1) : dy;
	assign in_box  = (adx <= {9'd0, radius_q}) && (ady <= {9'd0, radius_q});
	assign sq_x    = 16'(adx[7:0]) * 16'(adx[7:0]);
	assign sq_y    = 16'(ady[7:0]) * 16'(ady[7:0]);
	assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
	assign near    = in_box && (dist_sq <= {1'b0, radius_sq_q});

	// Track updates for one event.
	always_comb begin
		n_active     = active_q;
		n_single     = single_alive_q;
		n_done       = single_done_q;
		n_double     = double_alive_q;
		n_ups        = ups_seen_q;
		n_start_x    = start_x_q;
		n_start_y    = start_y_q;
		n_start_time = start_time_q;
		n_owner      = owner_q;
		code         = OUT_IDLE;
		do_resolve   = 1'b0;
		do_begin     = 1'b0;
		began_idle   = 1'b0;

		if (cmd.cls == CLS_IGNORE) begin
			code = active_q ? OUT_PENDING : OUT_IDLE;
		end else if (!active_q) begin
			do_begin   = (cmd.cls == CLS_DOWN);
			began_idle = 1'b1;
		end else if (cmd.cls == CLS_TICK) begin
			if (single_alive_q && !el_le_tap) begin
				n_single = 1'b0;
			end
			if (double_alive_q && !el_le_double) begin
				n_double = 1'b0;
			end
			do_resolve = 1'b1;
		end else if (cmd.pointer_id != owner_q) begin
			code = OUT_PENDING;
		end else begin
			unique case (cmd.cls)
				CLS_DOWN: begin
					n_single = 1'b0;
					if (double_alive_q && !(near && el_le_tap)) begin
						n_double = 1'b0;
					end
					if (!n_double) begin
						code     = single_done_q ? OUT_TAP : OUT_FAIL;
						do_begin = 1'b1;
					end else begin
						do_resolve = 1'b1;
					end
				end
				CLS_UP: begin
					do_resolve = 1'b1;
					if (single_alive_q) begin
						n_single = 1'b0;
						if (near && el_le_tap) begin
							n_done = 1'b1;
						end
					end
					if (double_alive_q) begin
						if (near && el_le_double) begin
							if (ups_seen_q) begin
								n_active   = 1'b0;
								n_single   = 1'b0;
								n_done     = 1'b0;
								n_double   = 1'b0;
								n_ups      = 1'b0;
								code       = OUT_DOUBLE;
								do_resolve = 1'b0;
							end else begin
								n_ups = 1'b1;
							end
						end else begin
							n_double = 1'b0;
						end
					end
				end
				CLS_MOVE: begin
					if (!(near && el_le_tap)) begin
						n_single = 1'b0;
						n_double = 1'b0;
					end
					do_resolve = 1'b1;
				end
				default: begin
					n_single   = 1'b0;
					n_double   = 1'b0;
					do_resolve = 1'b1;
				end
			endcase
		end

		// Settle the status of the candidate.
		if (do_resolve) begin
			priority if (n_double) begin
				code = OUT_PENDING;
			end else if (n_done) begin
				code = OUT_TAP;
			end else if (n_single) begin
				code = OUT_PENDING;
			end else begin
				code = OUT_FAIL;
			end
			if (code != OUT_PENDING) begin
				n_active = 1'b0;
				n_single = 1'b0;
				n_done   = 1'b0;
				n_double = 1'b0;
				n_ups    = 1'b0;
			end
		end

		// A new candidate starts from this down.
		if (do_begin) begin
			n_active = en_tap_q || en_double_q;
			n_single = en_tap_q;
			n_double = en_double_q;
			n_done   = 1'b0;
			n_ups    = 1'b0;
			if (en_tap_q || en_double_q) begin
				n_start_x    = cmd.pos_x;
				n_start_y    = cmd.pos_y;
				n_start_time = cmd.stamp_ms;
				n_owner      = cmd.pointer_id;
			end
		end

		if (began_idle) begin
			code = n_active ? OUT_PENDING : OUT_IDLE;
		end
	end

	// Result transaction; position from the new start when it began from idle.
	always_comb begin
		res_item.outcome = code;
		if (code == OUT_IDLE) begin
			res_item.gesture_x = '0;
			res_item.gesture_y = '0;
		end else if (began_idle) begin
			res_item.gesture_x = n_start_x;
			res_item.gesture_y = n_start_y;
		end else begin
			res_item.gesture_x = start_x_q;
			res_item.gesture_y = start_y_q;
		end
	end

	assign cmd_take = cmd_valid && !out_full;

	// Configuration registers; the squared radius is kept beside the radius.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q        <= RADIUS_RESET;
			radius_sq_q     <= 16'(RADIUS_RESET) * 16'(RADIUS_RESET);
			tap_window_q    <= TAP_WINDOW_RESET;
			double_window_q <= DOUBLE_WINDOW_RESET;
			en_tap_q        <= 1'b1;
			en_double_q     <= 1'b1;
		end else if (cfg.we) begin
			unique case (cfg.index)
				CFG_TAP_RADIUS: begin
					radius_q    <= cfg.data[7:0];
					radius_sq_q <= 16'(cfg.data[7:0]) * 16'(cfg.data[7:0]);
				end
				CFG_TAP_WINDOW:    tap_window_q    <= cfg.data;
				CFG_DOUBLE_WINDOW: double_window_q <= cfg.data;
				CFG_ENABLE_TAP:    en_tap_q        <= cfg.data[0];
				CFG_ENABLE_DOUBLE: en_double_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Candidate state advances on each evaluated event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			single_alive_q <= 1'b0;
			single_done_q  <= 1'b0;
			double_alive_q <= 1'b0;
			ups_seen_q     <= 1'b0;
			start_x_q      <= '0;
			start_y_q      <= '0;
			start_time_q   <= '0;
			owner_q        <= '0;
		end else if (cmd_take) begin
			active_q       <= n_active;
			single_alive_q <= n_single;
			single_done_q  <= n_done;
			double_alive_q <= n_double;
			ups_seen_q     <= n_ups;
			start_x_q      <= n_start_x;
			start_y_q      <= n_start_y;
			start_time_q   <= n_start_time;
			owner_q        <= n_owner;
		end
	end

	// Result queue toward the consumer.
	tdt_fifo #(
		.DEPTH (OUT_DEPTH),
		.WIDTH ($bits(out_item_t))
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_take),
		.wdata  (res_item),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

	// A live candidate always has at least one track in progress.
	a_active_has_track: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (single_alive_q || double_alive_q))
		else $error("candidate active with no track in progress");

	// A completed tap only exists within a candidate.
	a_done_in_candidate: assert property (@(posedge clk) disable iff (!arst_n)
		single_done_q |-> active_q)
		else $error("completed tap outside a candidate");

	// The first up of a double tap is only remembered while that track lives.
	a_ups_needs_double: assert property (@(posedge clk) disable iff (!arst_n)
		ups_seen_q |-> double_alive_q)
		else $error("first up recorded without a double-tap track");

	// State changes only when an event was evaluated.
	a_state_moves_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_take |=> $stable(start_time_q) && $stable(active_q))
		else $error("candidate state changed without an evaluated event");

endmodule

### rtl/tap_double_tap_recognizer.sv
// Flow: an accepted event waits in the middle queue and is evaluated at its head once the
// result queue has room; its result is then popped from there; one result per event, in order.
// Throughput: one event per cycle while the result queue has room; evaluation is combinational.
// Reset: arst_n clears both queues and the candidate, and restores the registers
// to radius 3, tap window 200 ms, double window 400 ms, both gestures enabled.
module tap_double_tap_recognizer import tdt_pkg::*; #(
	parameter int MID_DEPTH = MID_DEPTH_DEFAULT,
	parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  in_item_t               event_item,
	output logic                   empty,
	input  logic                   pop,
	output out_item_t              result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_wr_t cfg;
	cmd_t    cmd;
	logic    cmd_valid;
	logic    cmd_take;

	// Bundle the configuration write.
	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// Intake and classification.
	tdt_front #(
		.MID_DEPTH (MID_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.event_item (event_item),
		.cmd_valid  (cmd_valid),
		.cmd_take   (cmd_take),
		.cmd        (cmd)
	);

	// Gesture evaluation and result queue.
	tdt_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
